@@ rtl/core/bpa_pkg.sv @@
package bpa_pkg;

  localparam int FRAME_BITS_DEF = 16;
  localparam int MAX_ORDER_DEF  = 10;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int ORD_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int META_W   = 6;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_MEM    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_SIZE  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ORD_MISM  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_TOP = 2'd2;

  // Page metadata bit positions.
  localparam int META_LISTED = 4;
  localparam int META_ALLOC  = 5;

endpackage

@@ rtl/core/buddy_page_allocator.sv @@
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// command  | in_valid/in_ready, in_cmd, in_page_frame,    | in
//          | in_page_count                                |
// result   | out_valid/out_ready, out_status,             | out
//          | out_block_frame, out_pages_out               |
// config   | cfg_we, cfg_index, cfg_wdata                 | in
//
// One command is worked on at a time. Every page operation is a read, then a write,
// of the single page memory. An add pushes its carved blocks one after another, and
// an allocate may split larger blocks or coalesce smaller ones before it unlinks one.
// After reset the page memory is swept to zero, one entry a cycle; no command is taken
// until the sweep ends. A result waiting on out_ready does not block the next command
// transfer.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int FRAME_BITS = bpa_pkg::FRAME_BITS_DEF,
  parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bpa_pkg::CMD_W-1:0]      in_cmd,
  input  logic [FRAME_BITS-1:0]          in_page_frame,
  input  logic [FRAME_BITS:0]            in_page_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  output logic [FRAME_BITS-1:0]          out_block_frame,
  output logic [FRAME_BITS:0]            out_pages_out,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAME_BITS:0]            cfg_wdata
);

  localparam int FB = FRAME_BITS;
  localparam int CW = FRAME_BITS + 1;
  localparam int MW = META_W + 2 * CW;
  localparam int HW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int XW = ((FB > MAX_ORDER) ? FB : MAX_ORDER) + 2;
  localparam logic [CW-1:0] NIL = {1'b1, {FB{1'b0}}};
  localparam logic [ORD_W-1:0] MAXO = ORD_W'(MAX_ORDER);

  // Sequencer states.
  localparam logic [5:0] S_CLR  = 6'd0;
  localparam logic [5:0] S_IDLE = 6'd1;
  localparam logic [5:0] S_DEC  = 6'd2;
  localparam logic [5:0] S_FIN  = 6'd3;
  localparam logic [5:0] S_ADD  = 6'd4;
  localparam logic [5:0] S_ADDN = 6'd5;
  localparam logic [5:0] S_AL0  = 6'd6;
  localparam logic [5:0] S_ALS  = 6'd7;
  localparam logic [5:0] S_ALF  = 6'd8;
  localparam logic [5:0] S_ALM  = 6'd9;
  localparam logic [5:0] S_ALW  = 6'd10;
  localparam logic [5:0] S_FRR  = 6'd11;
  localparam logic [5:0] S_FRC  = 6'd12;
  localparam logic [5:0] S_SPS  = 6'd13;
  localparam logic [5:0] S_SPP  = 6'd14;
  localparam logic [5:0] S_SP1  = 6'd15;
  localparam logic [5:0] S_SP2  = 6'd16;
  localparam logic [5:0] S_SPC  = 6'd17;
  localparam logic [5:0] S_COO  = 6'd18;
  localparam logic [5:0] S_COT  = 6'd19;
  localparam logic [5:0] S_CONR = 6'd20;
  localparam logic [5:0] S_CONW = 6'd21;
  localparam logic [5:0] S_COB  = 6'd22;
  localparam logic [5:0] S_COU  = 6'd23;
  localparam logic [5:0] S_COP  = 6'd24;
  localparam logic [5:0] S_COR  = 6'd25;
  localparam logic [5:0] S_ULR  = 6'd26;
  localparam logic [5:0] S_ULC  = 6'd27;
  localparam logic [5:0] S_ULP  = 6'd28;
  localparam logic [5:0] S_ULN  = 6'd29;
  localparam logic [5:0] S_ULNW = 6'd30;
  localparam logic [5:0] S_ULF  = 6'd31;
  localparam logic [5:0] S_PUR  = 6'd32;
  localparam logic [5:0] S_PUC  = 6'd33;
  localparam logic [5:0] S_PUHR = 6'd34;
  localparam logic [5:0] S_PUHW = 6'd35;

  // Highest set bit; zero for a zero input.
  function automatic logic [4:0] flog2(input logic [CW-1:0] x);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  // Trailing zero count; all ones for a zero input, which never limits the order.
  function automatic logic [4:0] tzc(input logic [FB-1:0] x);
    logic [4:0] r;
    r = '1;
    for (int i = FB - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] mkent(input logic [CW-1:0] pv, input logic [CW-1:0] nx,
                                         input logic [META_W-1:0] meta);
    return {pv, nx, meta};
  endfunction

  logic [5:0]          st_r, st_nxt;
  logic [FB-1:0]       clr_r, clr_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [CW-1:0]       frm_r, frm_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ORD_W-1:0]    ord_r, ord_nxt;

  logic [FB-1:0]       u_f_r, u_f_nxt;
  logic [META_W-1:0]   u_meta_r, u_meta_nxt;
  logic [CW-1:0]       u_p_r, u_p_nxt;
  logic [CW-1:0]       u_n_r, u_n_nxt;
  logic [5:0]          u_ret_r, u_ret_nxt;

  logic [FB-1:0]       p_f_r, p_f_nxt;
  logic [ORD_W-1:0]    p_o_r, p_o_nxt;
  logic [CW-1:0]       p_h_r, p_h_nxt;
  logic [5:0]          p_ret_r, p_ret_nxt;

  logic [ORD_W-1:0]    sp_cur_r, sp_cur_nxt;
  logic [FB-1:0]       sp_pg_r, sp_pg_nxt;

  logic [ORD_W-1:0]    co_o_r, co_o_nxt;
  logic [ORD_W-1:0]    co_tgt_r, co_tgt_nxt;
  logic [CW-1:0]       co_cur_r, co_cur_nxt;
  logic [FB-1:0]       co_b_r, co_b_nxt;

  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [FB-1:0]       res_blk_r, res_blk_nxt;
  logic [CW-1:0]       res_pg_r, res_pg_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [FB-1:0]       out_blk_r, out_blk_nxt;
  logic [CW-1:0]       out_pg_r, out_pg_nxt;

  logic [FB-1:0]       zstart_r;
  logic [CW-1:0]       zend_r;
  logic [CW-1:0]       utop_r;

  logic [CW-1:0]       head_r [MAX_ORDER + 1];

  // Memory port and list head port.
  logic                ram_we, ram_re;
  logic [FB-1:0]       ram_wa, ram_ra;
  logic [MW-1:0]       ram_wd, ram_rd;
  logic                hw_en;
  logic [ORD_W-1:0]    hw_idx;
  logic [CW-1:0]       hw_val;
  logic [ORD_W-1:0]    hidx;
  logic [CW-1:0]       hd;

  logic [META_W-1:0]   rd_meta;
  logic [CW-1:0]       rd_nx, rd_pv;

  logic [CW-1:0]       end_eff;
  logic [CW:0]         add_sum;
  logic [4:0]          lg5, cl5, tz5, ao5;
  logic [ORD_W-1:0]    add_o;

  logic [XW-1:0]       co_sz, co_curx, co_bx, co_bend;
  logic                co_misal, co_bok;
  logic [XW-1:0]       sp_upper;
  logic [XW-1:0]       al_pages;

  bpa_ram #(.WIDTH(MW), .DEPTH(2 ** FB)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign rd_meta = ram_rd[META_W-1:0];
  assign rd_nx   = ram_rd[META_W +: CW];
  assign rd_pv   = ram_rd[META_W + CW +: CW];

  assign end_eff = (zend_r > NIL) ? NIL : zend_r;
  assign add_sum = {1'b0, frm_r} + {1'b0, cnt_r};

  // Add carving: the largest block that fits the count, the order cap and the alignment.
  assign lg5 = flog2(cnt_r);
  assign cl5 = lg5 + 5'(|(cnt_r & (cnt_r - CW'(1))));
  assign tz5 = tzc(frm_r[FB-1:0]);
  always_comb begin
    ao5 = lg5;
    if (ao5 > 5'(MAX_ORDER)) begin
      ao5 = 5'(MAX_ORDER);
    end
    if (ao5 > tz5) begin
      ao5 = tz5;
    end
  end
  assign add_o = ao5[ORD_W-1:0];

  // Buddy test for the coalescing walk.
  assign co_sz    = XW'(1) << co_o_r;
  assign co_curx  = XW'(co_cur_r[FB-1:0]);
  assign co_bx    = co_curx ^ co_sz;
  assign co_bend  = co_bx + co_sz;
  assign co_misal = (co_curx & ((co_sz << 1) - XW'(1))) != '0;
  assign co_bok   = (co_bx >= XW'(zstart_r)) && (co_bend <= XW'(end_eff)) &&
                    (co_bend <= XW'(utop_r));

  assign sp_upper = XW'(sp_pg_r) + (XW'(1) << sp_cur_r);
  assign al_pages = XW'(1) << ord_r;

  // One head read per cycle, its index chosen by the state.
  always_comb begin
    unique case (st_r)
      S_PUC:               hidx = p_o_r;
      S_SPS, S_SPP:        hidx = sp_cur_r;
      S_COO, S_COT, S_COR: hidx = co_o_r;
      default:             hidx = ord_r;
    endcase
  end
  assign hd = head_r[hidx[HW-1:0]];

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    frm_nxt       = frm_r;
    cnt_nxt       = cnt_r;
    ord_nxt       = ord_r;
    u_f_nxt       = u_f_r;
    u_meta_nxt    = u_meta_r;
    u_p_nxt       = u_p_r;
    u_n_nxt       = u_n_r;
    u_ret_nxt     = u_ret_r;
    p_f_nxt       = p_f_r;
    p_o_nxt       = p_o_r;
    p_h_nxt       = p_h_r;
    p_ret_nxt     = p_ret_r;
    sp_cur_nxt    = sp_cur_r;
    sp_pg_nxt     = sp_pg_r;
    co_o_nxt      = co_o_r;
    co_tgt_nxt    = co_tgt_r;
    co_cur_nxt    = co_cur_r;
    co_b_nxt      = co_b_r;
    res_st_nxt    = res_st_r;
    res_blk_nxt   = res_blk_r;
    res_pg_nxt    = res_pg_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_st_nxt    = out_st_r;
    out_blk_nxt   = out_blk_r;
    out_pg_nxt    = out_pg_r;
    ram_we        = 1'b0;
    ram_wa        = u_f_r;
    ram_wd        = '0;
    ram_re        = 1'b0;
    ram_ra        = u_f_r;
    hw_en         = 1'b0;
    hw_idx        = p_o_r;
    hw_val        = NIL;

    unique case (st_r)
      S_CLR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r;
        clr_nxt = clr_r + FB'(1);
        if (clr_r == '1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          frm_nxt = CW'(in_page_frame);
          cnt_nxt = in_page_count;
          st_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        res_st_nxt  = STS_OK;
        res_blk_nxt = '0;
        res_pg_nxt  = '0;
        ord_nxt     = cl5[ORD_W-1:0];
        unique case (cmd_r)
          CMD_ADD: begin
            if ((frm_r < CW'(zstart_r)) || (add_sum > (CW + 1)'(end_eff))) begin
              res_pg_nxt = cnt_r;
              st_nxt     = S_FIN;
            end else begin
              st_nxt = S_ADD;
            end
          end
          CMD_ALLOC, CMD_FREE: begin
            if ((cnt_r == '0) || (cl5 > 5'(MAX_ORDER))) begin
              res_st_nxt = STS_BAD_SIZE;
              st_nxt     = S_FIN;
            end else begin
              st_nxt = (cmd_r == CMD_ALLOC) ? S_AL0 : S_FRR;
            end
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_blk_nxt   = res_blk_r;
          out_pg_nxt    = res_pg_r;
          st_nxt        = S_IDLE;
        end
      end

      // Range carving.
      S_ADD: begin
        if (cnt_r == '0) begin
          st_nxt = S_FIN;
        end else begin
          p_o_nxt   = add_o;
          p_f_nxt   = frm_r[FB-1:0];
          p_ret_nxt = S_ADDN;
          st_nxt    = S_PUR;
        end
      end
      S_ADDN: begin
        cnt_nxt = cnt_r - (CW'(1) << p_o_r);
        frm_nxt = frm_r + (CW'(1) << p_o_r);
        st_nxt  = S_ADD;
      end

      // Allocation.
      S_AL0: begin
        if (hd != NIL) begin
          st_nxt = S_ALF;
        end else if (ord_r == MAXO) begin
          co_tgt_nxt = MAXO;
          co_o_nxt   = '0;
          st_nxt     = S_COO;
        end else begin
          sp_cur_nxt = ord_r + ORD_W'(1);
          st_nxt     = S_SPS;
        end
      end
      S_ALS: begin
        if ((hd == NIL) && (ord_r != '0)) begin
          co_tgt_nxt = ord_r;
          co_o_nxt   = '0;
          st_nxt     = S_COO;
        end else begin
          st_nxt = S_ALF;
        end
      end
      S_ALF: begin
        if (hd == NIL) begin
          res_st_nxt = STS_NO_MEM;
          st_nxt     = S_FIN;
        end else begin
          u_f_nxt   = hd[FB-1:0];
          sp_pg_nxt = hd[FB-1:0];
          u_ret_nxt = S_ALM;
          st_nxt    = S_ULR;
        end
      end
      S_ALM: begin
        ram_re = 1'b1;
        ram_ra = sp_pg_r;
        st_nxt = S_ALW;
      end
      S_ALW: begin
        ram_we                 = 1'b1;
        ram_wa                 = sp_pg_r;
        ram_wd                 = ram_rd;
        ram_wd[META_ALLOC]     = 1'b1;
        res_blk_nxt            = sp_pg_r;
        res_pg_nxt             = al_pages[CW-1:0];
        st_nxt                 = S_FIN;
      end

      // Free.
      S_FRR: begin
        ram_re = 1'b1;
        ram_ra = frm_r[FB-1:0];
        st_nxt = S_FRC;
      end
      S_FRC: begin
        if (!rd_meta[META_ALLOC]) begin
          res_st_nxt = STS_NOT_ALLOC;
          st_nxt     = S_FIN;
        end else if (rd_meta[ORD_W-1:0] != ord_r) begin
          res_st_nxt = STS_ORD_MISM;
          st_nxt     = S_FIN;
        end else begin
          ram_we             = 1'b1;
          ram_wa             = frm_r[FB-1:0];
          ram_wd             = ram_rd;
          ram_wd[META_ALLOC] = 1'b0;
          res_pg_nxt         = cnt_r;
          p_o_nxt            = ord_r;
          p_f_nxt            = frm_r[FB-1:0];
          p_ret_nxt          = S_FIN;
          st_nxt             = S_PUR;
        end
      end

      // Splitting: find the nearest larger non-empty order, then halve down.
      S_SPS: begin
        if (hd != NIL) begin
          st_nxt = S_SPP;
        end else if (sp_cur_r == MAXO) begin
          st_nxt = S_ALS;
        end else begin
          sp_cur_nxt = sp_cur_r + ORD_W'(1);
        end
      end
      S_SPP: begin
        sp_pg_nxt = hd[FB-1:0];
        u_f_nxt   = hd[FB-1:0];
        u_ret_nxt = S_SP1;
        st_nxt    = S_ULR;
      end
      S_SP1: begin
        sp_cur_nxt = sp_cur_r - ORD_W'(1);
        p_o_nxt    = sp_cur_r - ORD_W'(1);
        p_f_nxt    = sp_pg_r;
        p_ret_nxt  = S_SP2;
        st_nxt     = S_PUR;
      end
      S_SP2: begin
        p_o_nxt   = sp_cur_r;
        p_f_nxt   = sp_upper[FB-1:0];
        p_ret_nxt = S_SPC;
        st_nxt    = S_PUR;
      end
      S_SPC: begin
        st_nxt = (sp_cur_r > ord_r) ? S_SPP : S_ALS;
      end

      // Lazy coalescing of each order below the target.
      S_COO: begin
        if (co_o_r == co_tgt_r) begin
          st_nxt = S_ALF;
        end else begin
          co_cur_nxt = hd;
          st_nxt     = S_COT;
        end
      end
      S_COT: begin
        if (hd == NIL) begin
          co_o_nxt = co_o_r + ORD_W'(1);
          st_nxt   = S_COO;
        end else if (co_misal || !co_bok) begin
          st_nxt = S_CONR;
        end else begin
          co_b_nxt = co_bx[FB-1:0];
          ram_re   = 1'b1;
          ram_ra   = co_bx[FB-1:0];
          st_nxt   = S_COB;
        end
      end
      S_CONR: begin
        ram_re = 1'b1;
        ram_ra = co_cur_r[FB-1:0];
        st_nxt = S_CONW;
      end
      S_CONW: begin
        co_cur_nxt = rd_nx;
        if (rd_nx == NIL) begin
          co_o_nxt = co_o_r + ORD_W'(1);
          st_nxt   = S_COO;
        end else begin
          st_nxt = S_COT;
        end
      end
      S_COB: begin
        if (!rd_meta[META_LISTED] || (rd_meta[ORD_W-1:0] != co_o_r)) begin
          st_nxt = S_CONR;
        end else begin
          u_f_nxt   = co_cur_r[FB-1:0];
          u_ret_nxt = S_COU;
          st_nxt    = S_ULR;
        end
      end
      S_COU: begin
        u_f_nxt   = co_b_r;
        u_ret_nxt = S_COP;
        st_nxt    = S_ULR;
      end
      S_COP: begin
        p_o_nxt   = co_o_r + ORD_W'(1);
        p_f_nxt   = co_cur_r[FB-1:0];
        p_ret_nxt = S_COR;
        st_nxt    = S_PUR;
      end
      S_COR: begin
        co_cur_nxt = hd;
        st_nxt     = S_COT;
      end

      // Unlink of page u_f from the list its order names.
      S_ULR: begin
        ram_re = 1'b1;
        ram_ra = u_f_r;
        st_nxt = S_ULC;
      end
      S_ULC: begin
        if (!rd_meta[META_LISTED] || (rd_meta[ORD_W-1:0] > MAXO)) begin
          st_nxt = u_ret_r;
        end else begin
          u_meta_nxt = rd_meta;
          u_p_nxt    = rd_pv;
          u_n_nxt    = rd_nx;
          if (rd_pv != NIL) begin
            ram_re = 1'b1;
            ram_ra = rd_pv[FB-1:0];
            st_nxt = S_ULP;
          end else begin
            hw_en  = 1'b1;
            hw_idx = rd_meta[ORD_W-1:0];
            hw_val = rd_nx;
            st_nxt = S_ULN;
          end
        end
      end
      S_ULP: begin
        ram_we = 1'b1;
        ram_wa = u_p_r[FB-1:0];
        ram_wd = mkent(rd_pv, u_n_r, rd_meta);
        st_nxt = S_ULN;
      end
      S_ULN: begin
        if (u_n_r != NIL) begin
          ram_re = 1'b1;
          ram_ra = u_n_r[FB-1:0];
          st_nxt = S_ULNW;
        end else begin
          st_nxt = S_ULF;
        end
      end
      S_ULNW: begin
        ram_we = 1'b1;
        ram_wa = u_n_r[FB-1:0];
        ram_wd = mkent(u_p_r, rd_nx, rd_meta);
        st_nxt = S_ULF;
      end
      S_ULF: begin
        ram_we              = 1'b1;
        ram_wa              = u_f_r;
        ram_wd              = mkent(u_p_r, u_n_r, u_meta_r);
        ram_wd[META_LISTED] = 1'b0;
        st_nxt              = u_ret_r;
      end

      // Push of page p_f onto the head of list p_o; a listed page is unlinked first.
      S_PUR: begin
        ram_re = 1'b1;
        ram_ra = p_f_r;
        st_nxt = S_PUC;
      end
      S_PUC: begin
        if (rd_meta[META_LISTED]) begin
          u_f_nxt   = p_f_r;
          u_ret_nxt = S_PUR;
          st_nxt    = S_ULR;
        end else begin
          ram_we  = 1'b1;
          ram_wa  = p_f_r;
          ram_wd  = mkent(NIL, hd, {rd_meta[META_ALLOC], 1'b1, p_o_r});
          p_h_nxt = hd;
          hw_en   = 1'b1;
          hw_idx  = p_o_r;
          hw_val  = CW'(p_f_r);
          st_nxt  = (hd != NIL) ? S_PUHR : p_ret_r;
        end
      end
      S_PUHR: begin
        ram_re = 1'b1;
        ram_ra = p_h_r[FB-1:0];
        st_nxt = S_PUHW;
      end
      S_PUHW: begin
        ram_we = 1'b1;
        ram_wa = p_h_r[FB-1:0];
        ram_wd = mkent(CW'(p_f_r), rd_nx, rd_meta);
        st_nxt = p_ret_r;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      zstart_r    <= '0;
      zend_r      <= NIL;
      utop_r      <= NIL;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_r[i] <= NIL;
      end
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (hw_en) begin
        head_r[hw_idx[HW-1:0]] <= hw_val;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZONE_START: zstart_r <= cfg_wdata[FB-1:0];
          CFG_ZONE_END:   zend_r   <= cfg_wdata;
          CFG_USABLE_TOP: utop_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    frm_r     <= frm_nxt;
    cnt_r     <= cnt_nxt;
    ord_r     <= ord_nxt;
    u_f_r     <= u_f_nxt;
    u_meta_r  <= u_meta_nxt;
    u_p_r     <= u_p_nxt;
    u_n_r     <= u_n_nxt;
    u_ret_r   <= u_ret_nxt;
    p_f_r     <= p_f_nxt;
    p_o_r     <= p_o_nxt;
    p_h_r     <= p_h_nxt;
    p_ret_r   <= p_ret_nxt;
    sp_cur_r  <= sp_cur_nxt;
    sp_pg_r   <= sp_pg_nxt;
    co_o_r    <= co_o_nxt;
    co_tgt_r  <= co_tgt_nxt;
    co_cur_r  <= co_cur_nxt;
    co_b_r    <= co_b_nxt;
    res_st_r  <= res_st_nxt;
    res_blk_r <= res_blk_nxt;
    res_pg_r  <= res_pg_nxt;
    out_st_r  <= out_st_nxt;
    out_blk_r <= out_blk_nxt;
    out_pg_r  <= out_pg_nxt;
  end

  assign in_ready        = (st_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_block_frame = out_blk_r;
  assign out_pages_out   = out_pg_r;

endmodule

@@ rtl/core/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
